// ===== src/vlos_pkg.sv =====
// Shared types and constants for the voxel line-of-sight block.
// No dependencies; every other file of the block but vlos_ram imports this package.
`default_nettype none
package vlos_pkg;

  // Voxels per axis of the stored map, and the widths that follow from it.
  localparam int AXIS_SIZE = 32;
  localparam int AW        = $clog2(AXIS_SIZE);
  localparam int ROW_AW    = 2 * AW;
  localparam int ROWS      = 1 << ROW_AW;
  localparam int E_W       = AW + 4;

  localparam int COORD_W   = 6;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int STATUS_W  = 3;

  localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(32);
  localparam logic [COORD_W:0]   AXIS_LIM  = (COORD_W + 1)'(AXIS_SIZE);

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_X = 2'd0,
    CFG_GRID_Y = 2'd1,
    CFG_GRID_Z = 2'd2
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_WRITE_DONE = 3'd0,
    ST_CLEAR      = 3'd1,
    ST_OUTSIDE    = 3'd2,
    ST_END_OCC    = 3'd3,
    ST_BLOCKED    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [1:0] {
    RD_START = 2'd0,
    RD_GOAL  = 2'd1,
    RD_WALK  = 2'd2
  } rd_src_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_WRITE,
    S_RD_GOAL,
    S_CHK_END,
    S_WALK
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_item;
    logic    setup_walk;
    logic    rd_en;
    rd_src_t rd_src;
    logic    step;
    logic    latch_occ;
    logic    wr_row;
    logic    clr_wr;
    logic    res_load;
    status_t res_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic grid_ok;
    logic is_write;
    logic occ_bit;
    logic start_occ;
    logic cnt_zero;
    logic clr_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/vlos_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module vlos_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== src/vlos_datapath.sv =====
// Datapath of the voxel line-of-sight block: grid registers, item registers,
// Bresenham walk registers, occupancy map RAM and result registers.
// Depends on vlos_pkg and vlos_ram.
`default_nettype none
module vlos_datapath
  import vlos_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 kind,
  input  wire logic [COORD_W-1:0]   start_x,
  input  wire logic [COORD_W-1:0]   start_y,
  input  wire logic [COORD_W-1:0]   start_z,
  input  wire logic [COORD_W-1:0]   goal_x,
  input  wire logic [COORD_W-1:0]   goal_y,
  input  wire logic [COORD_W-1:0]   goal_z,
  input  wire logic                 occupied,
  input  wire cmd_t                 cmd,
  output      sts_t                 sts,
  output      logic                 visible,
  output      logic [STATUS_W-1:0]  status,
  output      logic                 done
);

  function automatic logic coord_ok(input logic [COORD_W-1:0] c,
                                    input logic [CFG_W-1:0]   lim);
    return (c < lim) && ({1'b0, c} < AXIS_LIM);
  endfunction

  function automatic logic [AW-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                             input logic [COORD_W-1:0] b);
    logic [COORD_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return d[AW-1:0];
  endfunction

  logic [CFG_W-1:0]   grid_x, grid_y, grid_z;
  logic               kind_r, occ_r;
  logic [COORD_W-1:0] sx, sy, sz, gx, gy, gz;

  logic [AW-1:0]      px, py, pz, cnt, rd_x;
  logic               sgn_x, sgn_y, sgn_z;
  axis_t              major;
  logic signed [E_W-1:0] da2, db2, dc2, e1, e2;
  logic               start_occ;
  logic [ROW_AW-1:0]  clr_cnt;
  logic               visible_r, done_r;
  status_t            status_r;

  // Walk setup terms, computed from the item registers.
  logic [AW-1:0]      dx, dy, dz, da_c, db_c, dc_c;
  axis_t              major_c;
  logic signed [E_W-1:0] da2_c, db2_c, dc2_c;

  // Step terms.
  logic               e1_pos, e2_pos, stx, sty, stz;

  // RAM ports.
  logic               ram_we, ram_re;
  logic [ROW_AW-1:0]  ram_waddr, ram_raddr;
  logic [AXIS_SIZE-1:0] ram_wdata, ram_rdata, row_mod;
  logic [AW-1:0]      rd_x_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_x <= CFG_RESET;
      grid_y <= CFG_RESET;
      grid_z <= CFG_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_GRID_X: grid_x <= cfg_data;
        CFG_GRID_Y: grid_y <= cfg_data;
        CFG_GRID_Z: grid_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_r <= kind;
      occ_r  <= occupied;
      sx     <= start_x;
      sy     <= start_y;
      sz     <= start_z;
      gx     <= goal_x;
      gy     <= goal_y;
      gz     <= goal_z;
    end
  end

  always_comb begin
    dx = abs_diff(gx, sx);
    dy = abs_diff(gy, sy);
    dz = abs_diff(gz, sz);
    // Ties go to x first, then y.
    if (dx >= dy && dx >= dz) begin
      major_c = AXIS_X;
      da_c    = dx;
      db_c    = dy;
      dc_c    = dz;
    end else if (dy >= dz) begin
      major_c = AXIS_Y;
      da_c    = dy;
      db_c    = dx;
      dc_c    = dz;
    end else begin
      major_c = AXIS_Z;
      da_c    = dz;
      db_c    = dy;
      dc_c    = dx;
    end
    da2_c = signed'(E_W'({da_c, 1'b0}));
    db2_c = signed'(E_W'({db_c, 1'b0}));
    dc2_c = signed'(E_W'({dc_c, 1'b0}));
  end

  // Minor axis b is y for an x or z walk and x for a y walk; minor axis c is
  // z for an x or y walk and x for a z walk.
  always_comb begin
    e1_pos = !e1[E_W-1] && (e1 != '0);
    e2_pos = !e2[E_W-1] && (e2 != '0);
    stx = (major == AXIS_X) || (major == AXIS_Y && e1_pos) || (major == AXIS_Z && e2_pos);
    sty = (major == AXIS_Y) || (major == AXIS_X && e1_pos) || (major == AXIS_Z && e1_pos);
    stz = (major == AXIS_Z) || (major == AXIS_X && e2_pos) || (major == AXIS_Y && e2_pos);
  end

  always_ff @(posedge clk) begin
    if (cmd.setup_walk) begin
      px    <= sx[AW-1:0];
      py    <= sy[AW-1:0];
      pz    <= sz[AW-1:0];
      sgn_x <= sx < gx;
      sgn_y <= sy < gy;
      sgn_z <= sz < gz;
      major <= major_c;
      da2   <= da2_c;
      db2   <= db2_c;
      dc2   <= dc2_c;
      e1    <= db2_c - signed'(E_W'(da_c));
      e2    <= dc2_c - signed'(E_W'(da_c));
      cnt   <= da_c;
    end else if (cmd.step) begin
      if (stx) px <= sgn_x ? px + 1'b1 : px - 1'b1;
      if (sty) py <= sgn_y ? py + 1'b1 : py - 1'b1;
      if (stz) pz <= sgn_z ? pz + 1'b1 : pz - 1'b1;
      e1  <= e1 + db2 - (e1_pos ? da2 : '0);
      e2  <= e2 + dc2 - (e2_pos ? da2 : '0);
      cnt <= cnt - 1'b1;
    end
  end

  // One RAM row holds every x of one (z, y) pair.
  always_comb begin
    case (cmd.rd_src)
      RD_START: begin
        ram_raddr = {sz[AW-1:0], sy[AW-1:0]};
        rd_x_c    = sx[AW-1:0];
      end
      RD_GOAL: begin
        ram_raddr = {gz[AW-1:0], gy[AW-1:0]};
        rd_x_c    = gx[AW-1:0];
      end
      RD_WALK: begin
        ram_raddr = {pz, py};
        rd_x_c    = px;
      end
      default: begin
        ram_raddr = {pz, py};
        rd_x_c    = px;
      end
    endcase
    ram_re = cmd.rd_en;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_x <= rd_x_c;
    end
    if (cmd.latch_occ) begin
      start_occ <= ram_rdata[rd_x];
    end
  end

  always_comb begin
    row_mod                = ram_rdata;
    row_mod[sx[AW-1:0]]    = occ_r;
    ram_we    = cmd.clr_wr || cmd.wr_row;
    ram_waddr = cmd.clr_wr ? clr_cnt : {sz[AW-1:0], sy[AW-1:0]};
    ram_wdata = cmd.clr_wr ? '0 : row_mod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  vlos_ram #(
    .WIDTH(AXIS_SIZE),
    .DEPTH(ROWS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done_r <= 1'b0;
    end else begin
      done_r <= cmd.res_load;
    end
    if (cmd.res_load) begin
      visible_r <= (cmd.res_status == ST_CLEAR);
      status_r  <= cmd.res_status;
    end
  end

  always_comb begin
    sts.grid_ok   = coord_ok(sx, grid_x) && coord_ok(sy, grid_y) && coord_ok(sz, grid_z) &&
                    (kind_r == KIND_WRITE ||
                     (coord_ok(gx, grid_x) && coord_ok(gy, grid_y) && coord_ok(gz, grid_z)));
    sts.is_write  = (kind_r == KIND_WRITE);
    sts.occ_bit   = ram_rdata[rd_x];
    sts.start_occ = start_occ;
    sts.cnt_zero  = (cnt == '0);
    sts.clr_last  = &clr_cnt;
  end

  assign visible = visible_r;
  assign status  = status_r;
  assign done    = done_r;

endmodule
`default_nettype wire

// ===== src/vlos_ctrl.sv =====
// Controller of the voxel line-of-sight block: sequences the map clear,
// the cell write, the endpoint checks and the walk. Depends on vlos_pkg.
`default_nettype none
module vlos_ctrl
  import vlos_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire sts_t sts,
  output      logic busy,
  output      cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:   if (sts.clr_last) state_next = S_IDLE;
      S_IDLE:    if (start) state_next = S_CHECK;
      S_CHECK: begin
        if (!sts.grid_ok)     state_next = S_IDLE;
        else if (sts.is_write) state_next = S_WRITE;
        else                  state_next = S_RD_GOAL;
      end
      S_WRITE:   state_next = S_IDLE;
      S_RD_GOAL: state_next = S_CHK_END;
      S_CHK_END: begin
        if (sts.start_occ || sts.occ_bit || sts.cnt_zero) state_next = S_IDLE;
        else state_next = S_WALK;
      end
      S_WALK: begin
        if (sts.occ_bit || sts.cnt_zero) state_next = S_IDLE;
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.rd_src     = RD_START;
    cmd.res_status = ST_WRITE_DONE;
    case (state)
      S_CLEAR: cmd.clr_wr = 1'b1;
      S_IDLE:  cmd.load_item = start;
      S_CHECK: begin
        cmd.setup_walk = 1'b1;
        if (!sts.grid_ok) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_OUTSIDE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_START;
        end
      end
      S_WRITE: begin
        cmd.wr_row     = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_WRITE_DONE;
      end
      S_RD_GOAL: begin
        cmd.latch_occ = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_src    = RD_GOAL;
      end
      S_CHK_END: begin
        if (sts.start_occ || sts.occ_bit) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_END_OCC;
        end else if (sts.cnt_zero) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_CLEAR;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_WALK;
          cmd.step   = 1'b1;
        end
      end
      S_WALK: begin
        // The bit on the RAM output belongs to the voxel read last cycle.
        if (sts.occ_bit) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_BLOCKED;
        end else if (sts.cnt_zero) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_CLEAR;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_WALK;
          cmd.step   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule
`default_nettype wire

// ===== src/voxel_line_of_sight.sv =====
// Top level of the voxel line-of-sight block: controller plus datapath.
// Depends on vlos_pkg, vlos_ctrl and vlos_datapath.
//
// An item is taken at a rising edge with start high and busy low. kind 0
// writes the occupied bit of cell (start_x, start_y, start_z); kind 1 asks
// whether the line from the start point to the goal point is clear. Each
// item gives one result on visible and status, held for one cycle while
// done is high; the receiver cannot stall, so it must take it then.
// The grid size registers are written over cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high. Writes must go in while
// idle; the block itself does not enforce it. An item outside the grid
// ends at the grid check, a write goes through the check and the row write,
// and a query reads both endpoints and ends at the endpoint check if either
// is occupied or they are equal, else walks d steps along the dominant axis;
// a blocked walk ends sooner. The walk reads one map row per cycle from the
// single read port of the map RAM. A new item can be accepted in the cycle
// done is high, but not while an earlier item is still in progress.
// After reset the map is cleared one row per cycle, all 1024 rows, with
// busy high; the grid registers reset to 32.
`default_nettype none
module voxel_line_of_sight
  import vlos_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output      logic                 busy,
  input  wire logic                 kind,
  input  wire logic [COORD_W-1:0]   start_x,
  input  wire logic [COORD_W-1:0]   start_y,
  input  wire logic [COORD_W-1:0]   start_z,
  input  wire logic [COORD_W-1:0]   goal_x,
  input  wire logic [COORD_W-1:0]   goal_y,
  input  wire logic [COORD_W-1:0]   goal_z,
  input  wire logic                 occupied,
  output      logic                 done,
  output      logic                 visible,
  output      logic [STATUS_W-1:0]  status,
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  vlos_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .sts  (sts),
    .busy (busy),
    .cmd  (cmd)
  );

  vlos_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .kind     (kind),
    .start_x  (start_x),
    .start_y  (start_y),
    .start_z  (start_z),
    .goal_x   (goal_x),
    .goal_y   (goal_y),
    .goal_z   (goal_z),
    .occupied (occupied),
    .cmd      (cmd),
    .sts      (sts),
    .visible  (visible),
    .status   (status),
    .done     (done)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an item was accepted");

  a_done_from_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without an item in progress");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two result strobes in a row");

  a_visible_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (visible == (status == ST_CLEAR)))
    else $error("visible disagrees with status");

endmodule
`default_nettype wire

// ===== verif/vlos_checker.sv =====
`timescale 1ns / 100ps
// Checker for the voxel line-of-sight block: keeps its own occupancy map and grid
// registers, predicts visible/status for every accepted item and compares results.
// Depends on vlos_pkg for widths, register indexes and status codes.
module vlos_checker
  import vlos_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic                 busy,
  input  wire logic                 kind,
  input  wire logic [COORD_W-1:0]   start_x,
  input  wire logic [COORD_W-1:0]   start_y,
  input  wire logic [COORD_W-1:0]   start_z,
  input  wire logic [COORD_W-1:0]   goal_x,
  input  wire logic [COORD_W-1:0]   goal_y,
  input  wire logic [COORD_W-1:0]   goal_z,
  input  wire logic                 occupied,
  input  wire logic                 done,
  input  wire logic                 visible,
  input  wire logic [STATUS_W-1:0]  status,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output int                        fail_count,
  output int                        outstanding
);

  localparam int CELLS = AXIS_SIZE * AXIS_SIZE * AXIS_SIZE;

  typedef struct packed {
    logic    visible;
    status_t status;
  } sight_t;

  bit             occ_map [CELLS];
  logic [CFG_W-1:0] grid_size [3];
  sight_t         sight_q [$];

  function automatic bit in_grid(int x, int y, int z);
    int lim [3];
    int n;
    for (n = 0; n < 3; n++) begin
      lim[n] = (int'(grid_size[n]) > AXIS_SIZE) ? AXIS_SIZE : int'(grid_size[n]);
    end
    return x < lim[0] && y < lim[1] && z < lim[2];
  endfunction

  function automatic int cell_of(int x, int y, int z);
    return (z * AXIS_SIZE + y) * AXIS_SIZE + x;
  endfunction

  // Cells beyond the stored map read as free.
  function automatic bit is_blocked(int x, int y, int z);
    if (x < 0 || y < 0 || z < 0 || x >= AXIS_SIZE || y >= AXIS_SIZE || z >= AXIS_SIZE)
      return 1'b0;
    return occ_map[cell_of(x, y, z)];
  endfunction

  // Applies a write to the map, or walks the line for a query.
  function automatic sight_t predict_sight(
    input logic k, input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
    input logic [COORD_W-1:0] sz, input logic [COORD_W-1:0] gx,
    input logic [COORD_W-1:0] gy, input logic [COORD_W-1:0] gz, input logic occ);
    int pos [3];
    int goal [3];
    int span [3];
    int dir [3];
    int a, b, c, n, e1, e2;
    bit clear;
    sight_t r;
    pos[0] = sx;
    pos[1] = sy;
    pos[2] = sz;
    goal[0] = gx;
    goal[1] = gy;
    goal[2] = gz;
    r.visible = 1'b0;
    if (k == KIND_WRITE) begin
      if (!in_grid(pos[0], pos[1], pos[2])) begin
        r.status = ST_OUTSIDE;
      end else begin
        occ_map[cell_of(pos[0], pos[1], pos[2])] = occ;
        r.status = ST_WRITE_DONE;
      end
      return r;
    end
    if (!in_grid(pos[0], pos[1], pos[2]) || !in_grid(goal[0], goal[1], goal[2])) begin
      r.status = ST_OUTSIDE;
      return r;
    end
    if (is_blocked(pos[0], pos[1], pos[2]) || is_blocked(goal[0], goal[1], goal[2])) begin
      r.status = ST_END_OCC;
      return r;
    end
    for (n = 0; n < 3; n++) begin
      span[n] = (pos[n] < goal[n]) ? goal[n] - pos[n] : pos[n] - goal[n];
      dir[n]  = (pos[n] < goal[n]) ? 1 : -1;
    end
    // Ties go to x first, then y.
    if (span[0] >= span[1] && span[0] >= span[2]) begin
      a = 0; b = 1; c = 2;
    end else if (span[1] >= span[0] && span[1] >= span[2]) begin
      a = 1; b = 0; c = 2;
    end else begin
      a = 2; b = 1; c = 0;
    end
    e1 = 2 * span[b] - span[a];
    e2 = 2 * span[c] - span[a];
    clear = 1'b1;
    // Each voxel is checked before the step, so the goal itself is never revisited.
    for (n = 0; n < span[a] && clear; n++) begin
      if (is_blocked(pos[0], pos[1], pos[2])) begin
        clear = 1'b0;
      end else begin
        if (e1 > 0) begin
          pos[b] += dir[b];
          e1 -= 2 * span[a];
        end
        if (e2 > 0) begin
          pos[c] += dir[c];
          e2 -= 2 * span[a];
        end
        e1 += 2 * span[b];
        e2 += 2 * span[c];
        pos[a] += dir[a];
      end
    end
    r.visible = clear;
    r.status  = clear ? ST_CLEAR : ST_BLOCKED;
    return r;
  endfunction

  always @(posedge clk) begin
    sight_t want;
    if (rst) begin
      foreach (occ_map[n]) occ_map[n] = 1'b0;
      foreach (grid_size[n]) grid_size[n] = CFG_RESET;
      sight_q.delete();
      fail_count = 0;
      outstanding <= 0;
    end else begin
      // The oldest expectation is matched before a same-edge item is queued.
      if (done) begin
        if (sight_q.size() == 0) begin
          $error("unexpected result: visible %0d, status %0d", visible, status);
          fail_count++;
        end else begin
          want = sight_q.pop_front();
          if (visible !== want.visible) begin
            $error("visible: expected %0d, actual %0d", want.visible, visible);
            fail_count++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready && cfg_index <= CFG_GRID_Z)
        grid_size[cfg_index] = cfg_data;
      if (start && !busy)
        sight_q = {sight_q, predict_sight(kind, start_x, start_y, start_z,
                                          goal_x, goal_y, goal_z, occupied)};
      outstanding <= sight_q.size();
    end
  end

endmodule

// ===== verif/voxel_line_of_sight_test.sv =====
`timescale 1ns / 100ps
// Top of the voxel line-of-sight testbench: clock, reset, grid setup and item stimulus.
// Depends on vlos_pkg, the block voxel_line_of_sight and the checker vlos_checker.
module voxel_line_of_sight_test;
  import vlos_pkg::*;

  localparam int TIMEOUT_NS = 5_000_000;
  localparam int MAX_GAP    = 12;
  localparam int COORD_MAX  = (1 << COORD_W) - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  // Grid x, y, z and number of items per phase; a negative size is drawn at random.
  localparam int PLAN [10][4] = '{
    '{8, 8, 8, 250}, '{63, 63, 63, 200}, '{4, 4, 4, 150}, '{1, 1, 1, 60},
    '{0, 8, 8, 60}, '{5, 12, 3, 250}, '{32, 1, 32, 200}, '{2, 32, 6, 200},
    '{-1, -1, -1, 180}, '{32, 32, 32, 330}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 kind = KIND_WRITE;
  logic [COORD_W-1:0]   start_x = '0;
  logic [COORD_W-1:0]   start_y = '0;
  logic [COORD_W-1:0]   start_z = '0;
  logic [COORD_W-1:0]   goal_x = '0;
  logic [COORD_W-1:0]   goal_y = '0;
  logic [COORD_W-1:0]   goal_z = '0;
  logic                 occupied = 1'b0;
  logic                 done;
  logic                 visible;
  logic [STATUS_W-1:0]  status;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_GRID_X;
  logic [CFG_W-1:0]     cfg_data = '0;
  int                   fail_count;
  int                   outstanding;

  // Stimulus shaping only: the grid extent in use along each axis.
  int grid_lim [3] = '{AXIS_SIZE, AXIS_SIZE, AXIS_SIZE};
  bit steady = 1'b0;

  voxel_line_of_sight u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .start_x(start_x), .start_y(start_y), .start_z(start_z),
    .goal_x(goal_x), .goal_y(goal_y), .goal_z(goal_z), .occupied(occupied),
    .done(done), .visible(visible), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  vlos_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .start_x(start_x), .start_y(start_y), .start_z(start_z),
    .goal_x(goal_x), .goal_y(goal_y), .goal_z(goal_z), .occupied(occupied),
    .done(done), .visible(visible), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fail_count(fail_count), .outstanding(outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic issue(input logic k, input int sx, input int sy, input int sz,
                       input int gx, input int gy, input int gz, input logic occ);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    kind     <= k;
    start_x  <= COORD_W'(sx);
    start_y  <= COORD_W'(sy);
    start_z  <= COORD_W'(sz);
    goal_x   <= COORD_W'(gx);
    goal_y   <= COORD_W'(gy);
    goal_z   <= COORD_W'(gz);
    occupied <= occ;
    do @(posedge clk); while (busy);
  endtask

  task automatic set_cell(input int x, input int y, input int z, input logic occ);
    issue(KIND_WRITE, x, y, z, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
          $urandom_range(0, COORD_MAX), occ);
  endtask

  task automatic ask_sight(input int sx, input int sy, input int sz,
                           input int gx, input int gy, input int gz);
    issue(KIND_QUERY, sx, sy, sz, gx, gy, gz, $urandom_range(0, 1));
  endtask

  task automatic wait_results();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_grid(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(value);
    do @(posedge clk); while (!cfg_ready);
    if (idx <= CFG_GRID_Z)
      grid_lim[idx] = (value > AXIS_SIZE) ? AXIS_SIZE : value;
  endtask

  // Mostly inside the grid, with a bias toward a small corner box so the map fills up.
  function automatic int pick_coord(input int lim);
    int r;
    r = $urandom_range(0, 99);
    if (lim == 0 || r < 6)
      return $urandom_range(0, COORD_MAX);
    if (r < 14)
      return r[0] ? 0 : lim - 1;
    if (r < 50)
      return $urandom_range(0, ((lim < 8) ? lim : 8) - 1);
    return $urandom_range(0, lim - 1);
  endfunction

  task automatic run_phase(input int count);
    int sx, sy, sz, gx, gy, gz;
    steady = ($urandom_range(0, 3) == 0);
    repeat (count) begin
      sx = pick_coord(grid_lim[0]);
      sy = pick_coord(grid_lim[1]);
      sz = pick_coord(grid_lim[2]);
      if ($urandom_range(0, 19) == 0) begin
        gx = sx; gy = sy; gz = sz;
      end else begin
        gx = pick_coord(grid_lim[0]);
        gy = pick_coord(grid_lim[1]);
        gz = pick_coord(grid_lim[2]);
      end
      issue(($urandom_range(0, 99) < 40) ? KIND_WRITE : KIND_QUERY, sx, sy, sz, gx, gy, gz,
            $urandom_range(0, 9) < 4);
      if ($urandom_range(0, 99) == 0)
        wait_results();
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed items on the full grid after reset.
    ask_sight(0, 0, 0, 31, 31, 31);
    ask_sight(31, 31, 31, 0, 0, 0);
    ask_sight(7, 7, 7, 7, 7, 7);
    ask_sight(32, 0, 0, 1, 1, 1);
    ask_sight(0, 0, 0, 0, 0, 63);
    set_cell(63, 63, 63, 1'b1);
    set_cell(31, 31, 31, 1'b1);
    ask_sight(0, 0, 0, 31, 31, 31);
    ask_sight(31, 31, 31, 0, 0, 0);
    set_cell(31, 31, 31, 1'b0);
    set_cell(3, 0, 0, 1'b1);
    ask_sight(0, 0, 0, 10, 0, 0);
    ask_sight(10, 0, 0, 0, 0, 0);
    ask_sight(0, 0, 0, 4, 4, 0);
    ask_sight(0, 0, 0, 0, 4, 4);
    ask_sight(0, 3, 0, 4, 0, 4);
    ask_sight(6, 2, 0, 0, 0, 0);
    set_cell(3, 0, 0, 1'b0);
    ask_sight(0, 0, 0, 10, 0, 0);
    ask_sight(0, 0, 0, 0, 0, 1);
    ask_sight(31, 0, 31, 0, 31, 0);

    for (int p = 0; p < 10; p++) begin
      wait_results();
      for (int a = 0; a < 3; a++) begin
        write_grid(cfg_reg_t'(a), (PLAN[p][a] < 0) ? $urandom_range(0, COORD_MAX)
                                                   : PLAN[p][a]);
      end
      // The unused index must leave every grid register alone.
      write_grid(CFG_UNUSED, $urandom_range(0, COORD_MAX));
      cfg_valid <= 1'b0;
      @(posedge clk);
      run_phase(PLAN[p][3]);
    end

    wait_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("[voxel_line_of_sight] OK");
    end else begin
      $display("[voxel_line_of_sight] ERROR");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("[voxel_line_of_sight] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/vlos_pkg.sv
src/vlos_ram.sv
src/vlos_datapath.sv
src/vlos_ctrl.sv
src/voxel_line_of_sight.sv
verif/vlos_checker.sv
verif/voxel_line_of_sight_test.sv
